// ===== rtl/cpu8_pkg.sv =====
// Shared types and codes for the 8-bit CPU arithmetic unit with its register file.
// Used by cpu8_exec and cpu8_alu_register_file_top. No dependencies.
package cpu8_pkg;

	// Instruction codes carried in the cmd field.
	localparam logic [2:0] CMD_NOP   = 3'd0;
	localparam logic [2:0] CMD_ADD_A = 3'd1;
	localparam logic [2:0] CMD_ADD_HL = 3'd2;
	localparam logic [2:0] CMD_SUB   = 3'd3;
	localparam logic [2:0] CMD_AND   = 3'd4;
	localparam logic [2:0] CMD_CP    = 3'd5;
	localparam logic [2:0] CMD_LOAD  = 3'd6;

	// Operand and load target codes.
	localparam logic [3:0] SEL_A   = 4'd6;
	localparam logic [3:0] SEL_IMM = 4'd7;
	localparam logic [3:0] SEL_SP  = 4'd8;

	// Register pair codes for ADD HL.
	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	// Positions in the general register file.
	localparam int unsigned GEN_B = 0;
	localparam int unsigned GEN_C = 1;
	localparam int unsigned GEN_D = 2;
	localparam int unsigned GEN_E = 3;
	localparam int unsigned GEN_H = 4;
	localparam int unsigned GEN_L = 5;
	localparam int unsigned GEN_COUNT = 6;

	// Flag bit positions.
	localparam int unsigned FLAG_Z = 3;
	localparam int unsigned FLAG_N = 2;
	localparam int unsigned FLAG_H = 1;
	localparam int unsigned FLAG_C = 0;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  source_select;
		logic [1:0]  pair_select;
		logic [15:0] operand_value;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0]  accumulator;
		logic [3:0]  flag_bits;
		logic [15:0] hl_pair;
		logic [1:0]  last_machine_cycles;
		logic [31:0] total_machine_cycles;
		logic [31:0] total_clock_cycles;
	} res_word_t;

	typedef struct packed {
		logic [7:0]                acc;
		logic [GEN_COUNT-1:0][7:0] gen;
		logic [15:0]               sp;
		logic [3:0]                flags;
		logic [31:0]               mc_total;
		logic [31:0]               clk_total;
	} arch_state_t;

endpackage

// ===== rtl/cpu8_exec.sv =====
// Combinational execution of one instruction against the architectural state.
// Depends on cpu8_pkg for the word, state and code definitions.
module cpu8_exec (
	input  cpu8_pkg::cmd_word_t   item,
	input  cpu8_pkg::arch_state_t cur,
	output cpu8_pkg::arch_state_t nxt,
	output cpu8_pkg::res_word_t   res
);

	logic [7:0]  a;
	logic [7:0]  b;
	logic [7:0]  imm;
	logic [1:0]  mc;
	logic [1:0]  op_mc;
	logic [8:0]  sum8;
	logic [4:0]  nib_sum;
	logic [7:0]  diff8;
	logic [7:0]  and8;
	logic [15:0] hl;
	logic [15:0] pair_val;
	logic [16:0] sum16;
	logic [12:0] low12_sum;

	assign a   = cur.acc;
	assign imm = item.operand_value[7:0];
	assign hl  = {cur.gen[cpu8_pkg::GEN_H], cur.gen[cpu8_pkg::GEN_L]};

	// Eight-bit operand: any select above A falls back to the immediate.
	always_comb begin
		op_mc = 2'd1;
		b     = imm;
		if (item.source_select < cpu8_pkg::SEL_A) begin
			b = cur.gen[item.source_select[2:0]];
		end else if (item.source_select == cpu8_pkg::SEL_A) begin
			b = a;
		end else begin
			op_mc = 2'd2;
		end
	end

	always_comb begin
		case (item.pair_select)
			cpu8_pkg::PAIR_BC: pair_val = {cur.gen[cpu8_pkg::GEN_B], cur.gen[cpu8_pkg::GEN_C]};
			cpu8_pkg::PAIR_DE: pair_val = {cur.gen[cpu8_pkg::GEN_D], cur.gen[cpu8_pkg::GEN_E]};
			cpu8_pkg::PAIR_HL: pair_val = hl;
			default:           pair_val = cur.sp;
		endcase
	end

	assign sum8      = {1'b0, a} + {1'b0, b};
	assign nib_sum   = {1'b0, a[3:0]} + {1'b0, b[3:0]};
	assign diff8     = a - b;
	assign and8      = a & b;
	assign sum16     = {1'b0, hl} + {1'b0, pair_val};
	assign low12_sum = {1'b0, hl[11:0]} + {1'b0, pair_val[11:0]};

	always_comb begin
		nxt = cur;
		mc  = 2'd0;
		unique case (item.cmd)
			cpu8_pkg::CMD_NOP: begin
				mc = 2'd1;
			end
			cpu8_pkg::CMD_ADD_A: begin
				mc = op_mc;
				nxt.acc = sum8[7:0];
				nxt.flags = '0;
				nxt.flags[cpu8_pkg::FLAG_Z] = (sum8[7:0] == 8'd0);
				nxt.flags[cpu8_pkg::FLAG_H] = nib_sum[4];
				nxt.flags[cpu8_pkg::FLAG_C] = sum8[8];
			end
			cpu8_pkg::CMD_ADD_HL: begin
				mc = 2'd2;
				nxt.gen[cpu8_pkg::GEN_H] = sum16[15:8];
				nxt.gen[cpu8_pkg::GEN_L] = sum16[7:0];
				nxt.flags[cpu8_pkg::FLAG_N] = 1'b0;
				nxt.flags[cpu8_pkg::FLAG_H] = low12_sum[12];
				nxt.flags[cpu8_pkg::FLAG_C] = sum16[16];
			end
			cpu8_pkg::CMD_SUB, cpu8_pkg::CMD_CP: begin
				mc = op_mc;
				if (item.cmd == cpu8_pkg::CMD_SUB) begin
					nxt.acc = diff8;
				end
				nxt.flags = '0;
				nxt.flags[cpu8_pkg::FLAG_Z] = (diff8 == 8'd0);
				nxt.flags[cpu8_pkg::FLAG_N] = 1'b1;
				nxt.flags[cpu8_pkg::FLAG_H] = (a[3:0] < b[3:0]);
				nxt.flags[cpu8_pkg::FLAG_C] = (a < b);
			end
			cpu8_pkg::CMD_AND: begin
				mc = op_mc;
				nxt.acc = and8;
				nxt.flags = '0;
				nxt.flags[cpu8_pkg::FLAG_Z] = (and8 == 8'd0);
				nxt.flags[cpu8_pkg::FLAG_H] = 1'b1;
			end
			cpu8_pkg::CMD_LOAD: begin
				// Loads are setup only: they add nothing to the cycle totals, flags untouched.
				if (item.source_select < cpu8_pkg::SEL_A) begin
					nxt.gen[item.source_select[2:0]] = imm;
				end else if (item.source_select == cpu8_pkg::SEL_A) begin
					nxt.acc = imm;
				end else if (item.source_select == cpu8_pkg::SEL_SP) begin
					nxt.sp = item.operand_value;
				end
			end
			default: begin
				mc = 2'd0;
			end
		endcase
		nxt.mc_total  = cur.mc_total + {30'd0, mc};
		nxt.clk_total = cur.clk_total + {28'd0, mc, 2'b00};
	end

	assign res.accumulator          = nxt.acc;
	assign res.flag_bits            = nxt.flags;
	assign res.hl_pair              = {nxt.gen[cpu8_pkg::GEN_H], nxt.gen[cpu8_pkg::GEN_L]};
	assign res.last_machine_cycles  = mc;
	assign res.total_machine_cycles = nxt.mc_total;
	assign res.total_clock_cycles   = nxt.clk_total;

endmodule

// ===== rtl/cpu8_alu_register_file_top.sv =====
// 8-bit CPU arithmetic unit with its register file, flags and cycle totals.
// Depends on cpu8_pkg and instantiates cpu8_exec.
//
// Usage:
// The cmd channel (cmd_valid, cmd_stall, cmd_word) takes one instruction per
// word. The res channel (res_valid, res_stall, res_word) returns one word per
// instruction, in order: A, the flags, HL, the machine cycles of this
// instruction and both running totals, all taken after it executes.
// A word accepted at a clock edge is registered in the input register,
// executed there against the register file and lands in the result
// register once that register can take it; then it is shown on res_word.
// Throughput is one instruction per clock unless res_stall holds the result:
// each is an 8-bit add, subtract, compare or AND, a 16-bit add, a load or a NOP,
// with flag logic between registers; the register file loads at the result's edge.
// When the receiver holds res_stall, the result waits in its register and the
// input register holds its word; cmd_stall rises only once both are full.
// Reset clears A, B, C, D, E, H, L, SP, the flags and both totals, and
// empties the pipeline.
module cpu8_alu_register_file_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  cpu8_pkg::cmd_word_t cmd_word,
	output logic                res_valid,
	input  logic                res_stall,
	output cpu8_pkg::res_word_t res_word
);

	logic                  valid_s1;
	cpu8_pkg::cmd_word_t   item_s1;
	logic                  res_valid_q;
	cpu8_pkg::res_word_t   res_word_q;
	cpu8_pkg::arch_state_t state_q;
	cpu8_pkg::arch_state_t state_nxt;
	cpu8_pkg::res_word_t   res_nxt;
	logic                  advance;
	logic                  exec_fire;

	// The result register can take a new word when empty or being drained.
	assign advance   = !res_valid_q || !res_stall;
	assign exec_fire = advance && valid_s1;
	assign cmd_stall = valid_s1 && !advance;

	cpu8_exec u_exec (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (exec_fire) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_word;
		end
		if (exec_fire) begin
			res_word_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

// ===== test/cpu8_alu_register_file_top_tb.sv =====
// Self-checking testbench for cpu8_alu_register_file_top: random and directed instruction words,
// a clocked driver and monitor, and a built-in predictor of the register file and cycle totals.
// Depends on cpu8_pkg and the RTL of cpu8_alu_register_file_top.
module cpu8_alu_register_file_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [3:0] SEL_NONE = 4'd9;
	localparam logic [3:0] SEL_TOP = 4'd15;
	localparam int RANDOM_WORDS = 1000;
	localparam int CYCLE_LIMIT = 300000;
	localparam int QUIET_FIRST = 300;
	localparam int QUIET_LAST = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cpu8_pkg::cmd_word_t cmd_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	cpu8_pkg::res_word_t res_word;

	cpu8_pkg::cmd_word_t pending_words[$];
	cpu8_pkg::res_word_t expected_results[$];
	cpu8_pkg::arch_state_t cpu_state = '0;
	cpu8_pkg::res_word_t want_word;
	logic cmd_taken = 1'b0;
	int cycle_count = 0;
	int error_count = 0;

	cpu8_alu_register_file_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word)
	);

	always #5 clk = ~clk;

	// 8-bit ALU operand; anything above A selects the immediate and raises mcyc.
	function automatic logic [7:0] operand_of(cpu8_pkg::cmd_word_t w, output logic [1:0] mcyc);
		mcyc = 2'd1;
		if (w.source_select <= cpu8_pkg::GEN_L)
			return cpu_state.gen[w.source_select[2:0]];
		if (w.source_select == cpu8_pkg::SEL_A)
			return cpu_state.acc;
		mcyc = 2'd2;
		return w.operand_value[7:0];
	endfunction

	// Executes one instruction word on the predicted register file and returns its result.
	function automatic cpu8_pkg::res_word_t execute_word(cpu8_pkg::cmd_word_t w);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] r;
		logic [8:0] sum9;
		logic [4:0] nib;
		logic [15:0] hl;
		logic [15:0] pr;
		logic [16:0] sum17;
		logic [12:0] low12;
		logic [1:0] mcyc;
		logic [3:0] f;
		cpu8_pkg::res_word_t res;
		a = cpu_state.acc;
		f = cpu_state.flags;
		mcyc = 2'd0;
		case (w.cmd)
			cpu8_pkg::CMD_NOP: mcyc = 2'd1;
			cpu8_pkg::CMD_ADD_A: begin
				b = operand_of(w, mcyc);
				sum9 = {1'b0, a} + {1'b0, b};
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]};
				f = 4'd0;
				f[cpu8_pkg::FLAG_Z] = (sum9[7:0] == 8'd0);
				f[cpu8_pkg::FLAG_H] = nib[4];
				f[cpu8_pkg::FLAG_C] = sum9[8];
				cpu_state.acc = sum9[7:0];
			end
			cpu8_pkg::CMD_ADD_HL: begin
				hl = {cpu_state.gen[cpu8_pkg::GEN_H], cpu_state.gen[cpu8_pkg::GEN_L]};
				case (w.pair_select)
					cpu8_pkg::PAIR_BC:
						pr = {cpu_state.gen[cpu8_pkg::GEN_B], cpu_state.gen[cpu8_pkg::GEN_C]};
					cpu8_pkg::PAIR_DE:
						pr = {cpu_state.gen[cpu8_pkg::GEN_D], cpu_state.gen[cpu8_pkg::GEN_E]};
					cpu8_pkg::PAIR_HL: pr = hl;
					default: pr = cpu_state.sp;
				endcase
				sum17 = {1'b0, hl} + {1'b0, pr};
				low12 = {1'b0, hl[11:0]} + {1'b0, pr[11:0]};
				// Zero survives a 16-bit add; the rest is rebuilt.
				f[cpu8_pkg::FLAG_N] = 1'b0;
				f[cpu8_pkg::FLAG_H] = low12[12];
				f[cpu8_pkg::FLAG_C] = sum17[16];
				cpu_state.gen[cpu8_pkg::GEN_H] = sum17[15:8];
				cpu_state.gen[cpu8_pkg::GEN_L] = sum17[7:0];
				mcyc = 2'd2;
			end
			cpu8_pkg::CMD_SUB, cpu8_pkg::CMD_CP: begin
				b = operand_of(w, mcyc);
				r = a - b;
				f = 4'd0;
				f[cpu8_pkg::FLAG_N] = 1'b1;
				f[cpu8_pkg::FLAG_Z] = (r == 8'd0);
				f[cpu8_pkg::FLAG_H] = (a[3:0] < b[3:0]);
				f[cpu8_pkg::FLAG_C] = (a < b);
				if (w.cmd == cpu8_pkg::CMD_SUB)
					cpu_state.acc = r;
			end
			cpu8_pkg::CMD_AND: begin
				b = operand_of(w, mcyc);
				r = a & b;
				f = 4'd0;
				f[cpu8_pkg::FLAG_H] = 1'b1;
				f[cpu8_pkg::FLAG_Z] = (r == 8'd0);
				cpu_state.acc = r;
			end
			cpu8_pkg::CMD_LOAD: begin
				if (w.source_select <= cpu8_pkg::GEN_L)
					cpu_state.gen[w.source_select[2:0]] = w.operand_value[7:0];
				else if (w.source_select == cpu8_pkg::SEL_A)
					cpu_state.acc = w.operand_value[7:0];
				else if (w.source_select == cpu8_pkg::SEL_SP)
					cpu_state.sp = w.operand_value;
			end
			default: ;
		endcase
		cpu_state.flags = f;
		cpu_state.mc_total = cpu_state.mc_total + 32'(mcyc);
		cpu_state.clk_total = cpu_state.clk_total + 32'({mcyc, 2'b00});
		res.accumulator = cpu_state.acc;
		res.flag_bits = cpu_state.flags;
		res.hl_pair = {cpu_state.gen[cpu8_pkg::GEN_H], cpu_state.gen[cpu8_pkg::GEN_L]};
		res.last_machine_cycles = mcyc;
		res.total_machine_cycles = cpu_state.mc_total;
		res.total_clock_cycles = cpu_state.clk_total;
		return res;
	endfunction

	task automatic push_word(logic [2:0] cmd, logic [3:0] sel, logic [1:0] pair,
			logic [15:0] val);
		cpu8_pkg::cmd_word_t w;
		w.cmd = cmd;
		w.source_select = sel;
		w.pair_select = pair;
		w.operand_value = val;
		pending_words.push_back(w);
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return {8'($urandom), 8'h0F};
			3: return {8'($urandom), 8'h80};
			4: return {8'($urandom), 8'h01};
			default: return 16'($urandom);
		endcase
	endfunction

	// Idles with a chance of 15 in a hundred, except inside one long quiet window.
	function automatic logic gap_roll();
		if (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST)
			return 1'b0;
		return ($urandom_range(0, 99) < 15);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || cmd_taken) begin
				if (pending_words.size() != 0 && !gap_roll()) begin
					cmd_word <= pending_words.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			res_stall <= gap_roll();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		cmd_taken <= cmd_valid && !cmd_stall;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expected_results.push_back(execute_word(cmd_word));
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result word with no instruction outstanding");
					error_count++;
				end else begin
					want_word = expected_results.pop_front();
					check_field("accumulator", 32'(want_word.accumulator),
						32'(res_word.accumulator));
					check_field("flag_bits", 32'(want_word.flag_bits), 32'(res_word.flag_bits));
					check_field("hl_pair", 32'(want_word.hl_pair), 32'(res_word.hl_pair));
					check_field("last_machine_cycles", 32'(want_word.last_machine_cycles),
						32'(res_word.last_machine_cycles));
					check_field("total_machine_cycles", want_word.total_machine_cycles,
						res_word.total_machine_cycles);
					check_field("total_clock_cycles", want_word.total_clock_cycles,
						res_word.total_clock_cycles);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [3:0] sel;
		int roll;
		// Directed part: flag corners of every operation and the odd selects.
		push_word(cpu8_pkg::CMD_NOP, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_BC, 16'h0000);
		push_word(cpu8_pkg::CMD_LOAD, cpu8_pkg::SEL_A, cpu8_pkg::PAIR_BC, 16'hAB0F);
		push_word(cpu8_pkg::CMD_LOAD, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_BC, 16'h0001);
		push_word(cpu8_pkg::CMD_ADD_A, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_BC, 16'h0000);
		push_word(cpu8_pkg::CMD_LOAD, 4'(cpu8_pkg::GEN_C), cpu8_pkg::PAIR_BC, 16'h00F0);
		push_word(cpu8_pkg::CMD_ADD_A, 4'(cpu8_pkg::GEN_C), cpu8_pkg::PAIR_BC, 16'h0000);
		push_word(cpu8_pkg::CMD_LOAD, cpu8_pkg::SEL_SP, cpu8_pkg::PAIR_BC, 16'hFFFF);
		push_word(cpu8_pkg::CMD_LOAD, 4'(cpu8_pkg::GEN_H), cpu8_pkg::PAIR_BC, 16'h0000);
		push_word(cpu8_pkg::CMD_LOAD, 4'(cpu8_pkg::GEN_L), cpu8_pkg::PAIR_BC, 16'h0001);
		push_word(cpu8_pkg::CMD_ADD_HL, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_SP, 16'h0000);
		push_word(cpu8_pkg::CMD_LOAD, 4'(cpu8_pkg::GEN_D), cpu8_pkg::PAIR_BC, 16'h000F);
		push_word(cpu8_pkg::CMD_LOAD, 4'(cpu8_pkg::GEN_E), cpu8_pkg::PAIR_BC, 16'h00FF);
		push_word(cpu8_pkg::CMD_ADD_HL, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_DE, 16'h0000);
		push_word(cpu8_pkg::CMD_ADD_HL, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_BC, 16'h0000);
		push_word(cpu8_pkg::CMD_ADD_HL, 4'(cpu8_pkg::GEN_B), cpu8_pkg::PAIR_HL, 16'h0000);
		push_word(cpu8_pkg::CMD_SUB, cpu8_pkg::SEL_IMM, cpu8_pkg::PAIR_BC, 16'h0001);
		push_word(cpu8_pkg::CMD_SUB, cpu8_pkg::SEL_A, cpu8_pkg::PAIR_BC, 16'h0000);
		// Operand selects above the immediate still take the immediate.
		push_word(cpu8_pkg::CMD_CP, SEL_TOP, cpu8_pkg::PAIR_BC, 16'h0080);
		push_word(cpu8_pkg::CMD_AND, cpu8_pkg::SEL_SP, cpu8_pkg::PAIR_BC, 16'h00FF);
		push_word(cpu8_pkg::CMD_LOAD, cpu8_pkg::SEL_A, cpu8_pkg::PAIR_BC, 16'hFFFF);
		push_word(cpu8_pkg::CMD_AND, cpu8_pkg::SEL_IMM, cpu8_pkg::PAIR_BC, 16'h000F);
		// Loads to targets that name no register change nothing.
		push_word(cpu8_pkg::CMD_LOAD, cpu8_pkg::SEL_IMM, cpu8_pkg::PAIR_BC, 16'hFFFF);
		push_word(cpu8_pkg::CMD_LOAD, SEL_NONE, cpu8_pkg::PAIR_BC, 16'hFFFF);
		push_word(cpu8_pkg::CMD_LOAD, SEL_TOP, cpu8_pkg::PAIR_SP, 16'hFFFF);
		push_word(CMD_UNUSED, SEL_TOP, cpu8_pkg::PAIR_SP, 16'hFFFF);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 25) begin
				sel = (roll < 3) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 8));
				push_word(cpu8_pkg::CMD_LOAD, sel, 2'($urandom), rand_value());
			end else begin
				sel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
					: 4'($urandom_range(0, 7));
				push_word(3'($urandom_range(0, 7)), sel, 2'($urandom), rand_value());
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || cmd_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
